// File: rtl/core/sps_pkg.sv
// Package for the segment plane slab clipper.
// Holds widths, register indexes, the queue entry type and the divider step.
// Used by every module under rtl/core.
package sps_pkg;

  localparam int EDGE_ID_BITS = 20;
  localparam int UP_W         = 52;
  localparam int HT_W         = 52;
  localparam int DN_W         = 53;
  localparam int FRAC_BITS    = 16;
  localparam int PARAM_W      = 17;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    REG_NORMAL_X   = 3'd0,
    REG_NORMAL_Y   = 3'd1,
    REG_NORMAL_Z   = 3'd2,
    REG_PLANE_OFF  = 3'd3,
    REG_HALF_WIDTH = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_FULL = 2'd1,
    MODE_DIV  = 2'd2
  } clip_mode_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [31:0] d;
    logic [30:0]        eps;
  } cfg_t;

  typedef struct packed {
    logic [EDGE_ID_BITS-1:0] edge_id;
    logic                    rev;
    logic                    emit;
    logic                    pos;
    clip_mode_t              a_mode;
    clip_mode_t              b_mode;
    logic [HT_W-1:0]         a_num;
    logic [HT_W-1:0]         b_num;
    logic [HT_W-1:0]         den;
  } cls_t;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1 << FRAC_BITS);

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [HT_W:0] div_step(logic [HT_W-1:0] r, logic [HT_W-1:0] d);
    logic [HT_W:0] sh;
    logic [HT_W:0] df;
    sh = {r, 1'b0};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      return {1'b1, df[HT_W-1:0]};
    end else begin
      return {1'b0, sh[HT_W-1:0]};
    end
  endfunction

endpackage

// File: rtl/core/sps_front.sv
// Front part: accepts edges, computes the signed distances and classifies them.
// Two register stages; depends on sps_pkg.
module sps_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sps_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sps_pkg::EDGE_ID_BITS-1:0] in_edge_index,
  input  logic signed [31:0]               in_org_x,
  input  logic signed [31:0]               in_org_y,
  input  logic signed [31:0]               in_org_z,
  input  logic signed [31:0]               in_dest_x,
  input  logic signed [31:0]               in_dest_y,
  input  logic signed [31:0]               in_dest_z,
  output logic                             push_valid,
  output sps_pkg::cls_t                    push_data,
  input  logic                             q_full
);
  import sps_pkg::*;

  logic                    en;
  logic                    s1_v_r, s2_v_r;
  logic [EDGE_ID_BITS-1:0] s1_id_r, s2_id_r;
  logic signed [47:0]      prod_r [6];
  logic signed [32:0]      off_r;
  logic signed [UP_W-1:0]  up1_r, up2_r;
  logic signed [UP_W-1:0]  up1_nxt, up2_nxt, lo, hi;
  logic signed [DN_W-1:0]  twoeps, down1, down2, ht_s;
  logic [HT_W-1:0]         height;
  logic                    rev, flat;

  assign en       = !s2_v_r || !q_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_id_r   <= in_edge_index;
      prod_r[0] <= cfg.nx * in_org_x;
      prod_r[1] <= cfg.ny * in_org_y;
      prod_r[2] <= cfg.nz * in_org_z;
      prod_r[3] <= cfg.nx * in_dest_x;
      prod_r[4] <= cfg.ny * in_dest_y;
      prod_r[5] <= cfg.nz * in_dest_z;
      off_r     <= {cfg.d[31], cfg.d} + $signed({2'b00, cfg.eps});
      s2_id_r   <= s1_id_r;
      up1_r     <= up1_nxt;
      up2_r     <= up2_nxt;
    end
  end

  always_comb begin
    up1_nxt = UP_W'(prod_r[0]) + UP_W'(prod_r[1]) + UP_W'(prod_r[2])
            - (UP_W'(off_r) <<< 15);
    up2_nxt = UP_W'(prod_r[3]) + UP_W'(prod_r[4]) + UP_W'(prod_r[5])
            - (UP_W'(off_r) <<< 15);
  end

  always_comb begin
    rev    = up1_r > up2_r;
    lo     = rev ? up2_r : up1_r;
    hi     = rev ? up1_r : up2_r;
    twoeps = $signed({6'b000000, cfg.eps, 16'h0000});
    down1  = -DN_W'(lo) - twoeps;
    down2  = -DN_W'(hi) - twoeps;
    height = HT_W'(hi - lo);
    ht_s   = $signed({1'b0, height});
    flat   = (height == '0);

    push_data.edge_id = s2_id_r;
    push_data.rev     = rev;
    push_data.pos     = (down1 <= 0) && (down2 <= 0);
    push_data.den     = height;
    if (flat) begin
      push_data.emit = ((down1 < 0) && (lo < 0)) || ((cfg.eps != '0) && (down1 == 0));
    end else begin
      push_data.emit = (down2 <= 0) && (lo < 0);
    end

    push_data.a_num = '0;
    if (flat || down1 <= 0) begin
      push_data.a_mode = MODE_ZERO;
    end else if (down1 >= ht_s) begin
      push_data.a_mode = MODE_FULL;
    end else begin
      push_data.a_mode = MODE_DIV;
      push_data.a_num  = HT_W'(down1);
    end

    push_data.b_num = '0;
    if (flat || hi <= 0) begin
      push_data.b_mode = MODE_FULL;
    end else if (DN_W'(hi) >= ht_s) begin
      push_data.b_mode = MODE_ZERO;
    end else begin
      push_data.b_mode = MODE_DIV;
      push_data.b_num  = HT_W'(hi);
    end
  end

  assign push_valid = s2_v_r;

endmodule

// File: rtl/core/sps_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on sps_pkg.
module sps_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  sps_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop_req,
  output logic          empty,
  output sps_pkg::cls_t head
);
  import sps_pkg::*;

  cls_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;
  logic            push, pop;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign push  = push_valid && !full;
  assign pop   = pop_req && !empty;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// File: rtl/core/sps_back.sv
// Back part: sixteen pipelined divider steps for both parameters and the output register.
// Depends on sps_pkg.
module sps_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  sps_pkg::cls_t                     q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sps_pkg::EDGE_ID_BITS-1:0]  out_edge_id_out,
  output logic                              out_reversed,
  output logic                              out_section_emitted,
  output logic [sps_pkg::PARAM_W-1:0]       out_entry_param,
  output logic [sps_pkg::PARAM_W-1:0]       out_exit_param,
  output logic                              out_positive_side
);
  import sps_pkg::*;

  logic                 en;
  logic                 v_r  [FRAC_BITS];
  cls_t                 st_r [FRAC_BITS];
  logic [FRAC_BITS-1:0] qa_r [FRAC_BITS];
  logic [FRAC_BITS-1:0] qb_r [FRAC_BITS];
  logic                 out_valid_r;
  logic [PARAM_W-1:0]   a_val, b_val;
  cls_t                 fin;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en;

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    cls_t                 src;
    cls_t                 st_nxt;
    logic [FRAC_BITS-1:0] qa_src, qb_src;
    logic [HT_W:0]        sa, sb;
    if (k == 0) begin : g_first
      assign src    = q_head;
      assign qa_src = '0;
      assign qb_src = '0;
    end else begin : g_rest
      assign src    = st_r[k-1];
      assign qa_src = qa_r[k-1];
      assign qb_src = qb_r[k-1];
    end
    assign sa = div_step(src.a_num, src.den);
    assign sb = div_step(src.b_num, src.den);

    always_comb begin
      st_nxt       = src;
      st_nxt.a_num = sa[HT_W-1:0];
      st_nxt.b_num = sb[HT_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= (k == 0) ? !q_empty : v_r[k > 0 ? k-1 : 0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
        qa_r[k] <= {qa_src[FRAC_BITS-2:0], sa[HT_W]};
        qb_r[k] <= {qb_src[FRAC_BITS-2:0], sb[HT_W]};
      end
    end
  end

  assign fin = st_r[FRAC_BITS-1];

  always_comb begin
    case (fin.a_mode)
      MODE_FULL: a_val = PARAM_ONE;
      MODE_DIV:  a_val = {1'b0, qa_r[FRAC_BITS-1]};
      default:   a_val = '0;
    endcase
    case (fin.b_mode)
      MODE_ZERO: b_val = '0;
      MODE_DIV:  b_val = PARAM_ONE - {1'b0, qb_r[FRAC_BITS-1]};
      default:   b_val = PARAM_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[FRAC_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_edge_id_out     <= fin.edge_id;
      out_reversed        <= fin.rev;
      out_section_emitted <= fin.emit;
      out_positive_side   <= fin.pos;
      out_entry_param     <= a_val;
      out_exit_param      <= b_val;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/segment_plane_slab_clip_top.sv
// Top level of the segment plane slab clipper: configuration registers,
// front part, queue and back part. Depends on sps_pkg and the sps_ modules.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   edge index, origin and destination
//   out      output     out_valid / out_ready flags, entry and exit parameters
//   cfg      input      cfg_valid / cfg_ready register index and data
//
// One item is accepted per cycle unless the queue is full and the front part holds
// an item. An item passes the distance multiplier and adder registers, the queue,
// the divider step registers and the output register. Synchronous reset restores
// the register defaults and empties the pipeline. A stalled output freezes the back
// part; the queue lets the front part keep accepting until it fills.
module segment_plane_slab_clip_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sps_pkg::EDGE_ID_BITS-1:0]  in_edge_index,
  input  logic signed [31:0]                in_org_x,
  input  logic signed [31:0]                in_org_y,
  input  logic signed [31:0]                in_org_z,
  input  logic signed [31:0]                in_dest_x,
  input  logic signed [31:0]                in_dest_y,
  input  logic signed [31:0]                in_dest_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sps_pkg::EDGE_ID_BITS-1:0]  out_edge_id_out,
  output logic                              out_reversed,
  output logic                              out_section_emitted,
  output logic [sps_pkg::PARAM_W-1:0]       out_entry_param,
  output logic [sps_pkg::PARAM_W-1:0]       out_exit_param,
  output logic                              out_positive_side
);
  import sps_pkg::*;

  cfg_t cfg_r;
  logic push_valid, q_full, q_empty, q_pop;
  cls_t push_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nx  <= '0;
      cfg_r.ny  <= '0;
      cfg_r.nz  <= 16'sd32767;
      cfg_r.d   <= '0;
      cfg_r.eps <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NORMAL_X:   cfg_r.nx  <= cfg_data[15:0];
        REG_NORMAL_Y:   cfg_r.ny  <= cfg_data[15:0];
        REG_NORMAL_Z:   cfg_r.nz  <= cfg_data[15:0];
        REG_PLANE_OFF:  cfg_r.d   <= cfg_data;
        REG_HALF_WIDTH: cfg_r.eps <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  sps_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid, .in_ready, .in_edge_index,
    .in_org_x, .in_org_y, .in_org_z, .in_dest_x, .in_dest_y, .in_dest_z,
    .push_valid, .push_data, .q_full
  );

  sps_queue u_queue (
    .clk, .rst_n, .push_valid, .push_data, .full(q_full),
    .pop_req(q_pop), .empty(q_empty), .head(q_head)
  );

  sps_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .out_valid, .out_ready,
    .out_edge_id_out, .out_reversed, .out_section_emitted,
    .out_entry_param, .out_exit_param, .out_positive_side
  );

endmodule

// File: test/tb_top.sv
// Testbench for segment_plane_slab_clip_top: sends edges, checks clip flags and parameters.
// Builds its own prediction from the plane and slab settings; depends on sps_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import sps_pkg::*;

  typedef struct packed {
    logic [EDGE_ID_BITS-1:0] id;
    logic                    rev;
    logic                    emit;
    logic [PARAM_W-1:0]      a;
    logic [PARAM_W-1:0]      b;
    logic                    pos;
  } clip_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [EDGE_ID_BITS-1:0] in_edge_index = '0;
  logic signed [31:0] in_org_x = 0, in_org_y = 0, in_org_z = 0;
  logic signed [31:0] in_dest_x = 0, in_dest_y = 0, in_dest_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [EDGE_ID_BITS-1:0] out_edge_id_out;
  logic out_reversed, out_section_emitted, out_positive_side;
  logic [PARAM_W-1:0] out_entry_param, out_exit_param;

  segment_plane_slab_clip_top dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  longint nx_q = 0, ny_q = 0, nz_q = 32767, off_q = 0, eps_q = 0;
  clip_res_t clip_expected[$];
  int n_mismatch = 0, n_checked = 0, n_emitted = 0, n_sent = 0;
  bit idle_on = 1;
  int stall_cnt = 0, quiet_cycles = 0;

  function automatic longint up_distance(longint x, longint y, longint z);
    return nx_q * x + ny_q * y + nz_q * z - (off_q + eps_q) * 32768;
  endfunction

  function automatic longint frac_q16(longint num, longint den);
    longint r = num, q = 0;
    for (int i = 0; i < 16; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic clip_res_t clip_edge(logic [EDGE_ID_BITS-1:0] id,
      logic signed [31:0] ox, logic signed [31:0] oy, logic signed [31:0] oz,
      logic signed [31:0] dx, logic signed [31:0] dy, logic signed [31:0] dz);
    clip_res_t r;
    longint u1, u2, t, d1, d2, h, a, b;
    u1 = up_distance(ox, oy, oz);
    u2 = up_distance(dx, dy, dz);
    r = '0;
    r.id = id;
    a = 0;
    b = 65536;
    if (u1 > u2) begin
      t = u1; u1 = u2; u2 = t;
      r.rev = 1'b1;
    end
    d1 = -u1 - eps_q * 65536;
    d2 = -u2 - eps_q * 65536;
    h = u2 - u1;
    if (h == 0) begin
      if ((d1 < 0 && u1 < 0) || (eps_q > 0 && d1 == 0)) r.emit = 1'b1;
    end else begin
      if (d1 > 0) a = (d1 >= h) ? 65536 : frac_q16(d1, h);
      if (u2 > 0) b = (u2 >= h) ? 0 : 65536 - frac_q16(u2, h);
      if (d2 <= 0 && u1 < 0) r.emit = 1'b1;
    end
    r.a = a[PARAM_W-1:0];
    r.b = b[PARAM_W-1:0];
    r.pos = (d1 <= 0 && d2 <= 0);
    return r;
  endfunction

  task automatic idle_gap();
    if (idle_on && $urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(17, 1)) @(negedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NORMAL_X: nx_q = longint'($signed(val[15:0]));
      REG_NORMAL_Y: ny_q = longint'($signed(val[15:0]));
      REG_NORMAL_Z: nz_q = longint'($signed(val[15:0]));
      REG_PLANE_OFF: off_q = longint'($signed(val));
      REG_HALF_WIDTH: eps_q = longint'(val[30:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_plane(logic [15:0] x, logic [15:0] y, logic [15:0] z,
      logic [31:0] d, logic [31:0] e);
    in_valid <= 0;
    wait (clip_expected.size() == 0);
    repeat (25) @(negedge clk);
    write_reg(REG_NORMAL_X, {16'h0, x});
    write_reg(REG_NORMAL_Y, {16'h0, y});
    write_reg(REG_NORMAL_Z, {16'h0, z});
    write_reg(REG_PLANE_OFF, d);
    write_reg(REG_HALF_WIDTH, e);
  endtask

  task automatic send_edge(logic [EDGE_ID_BITS-1:0] id,
      logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    idle_gap();
    in_valid <= 1;
    in_edge_index <= id;
    in_org_x <= ox; in_org_y <= oy; in_org_z <= oz;
    in_dest_x <= dx; in_dest_y <= dy; in_dest_z <= dz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    clip_expected.insert(clip_expected.size(), clip_edge(id, ox, oy, oz, dx, dy, dz));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return $urandom_range(8) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  task automatic random_edges(int count);
    logic [31:0] ox, oy, oz;
    for (int i = 0; i < count; i++) begin
      ox = rand_coord(); oy = rand_coord(); oz = rand_coord();
      case ($urandom_range(4))
        0: send_edge(20'($urandom), ox, oy, oz, ox, oy, oz);
        1: send_edge(20'($urandom), ox, oy, oz, ox, oy, oz + $urandom_range(0, 3) - 1);
        default: send_edge(20'($urandom), ox, oy, oz, rand_coord(), rand_coord(),
                           rand_coord());
      endcase
    end
  endtask

  task automatic test_directed_default();
    send_edge('0, 0, 0, 0, 0, 0, 0);
    send_edge('1, 0, 0, 32'h10000, 0, 0, 32'hffff0000);
    send_edge(20'h5a5a5, 0, 0, 32'hffff0000, 0, 0, 32'h10000);
    send_edge(20'ha5a5a, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h80000000);
    send_edge(20'h12345, 0, 0, 32'hfffe0000, 0, 0, 32'hffff0000);
    send_edge(20'h00001, 0, 0, 32'h20000, 0, 0, 32'h30000);
  endtask

  task automatic test_directed_slab();
    set_plane(16'h0000, 16'h0000, 16'h7fff, 32'h0001_0000, 32'h0000_8000);
    send_edge(1, 0, 0, 32'h8000, 0, 0, 32'h8000);
    send_edge(2, 0, 0, 32'h18000, 0, 0, 32'h18000);
    send_edge(3, 0, 0, 32'h10000, 0, 0, 32'h10000);
    send_edge(4, 0, 0, 0, 0, 0, 32'h20000);
    send_edge(5, 0, 0, 32'h30000, 0, 0, 32'hfffd0000);
    send_edge(6, 0, 0, 32'h9000, 0, 0, 32'h17000);
    send_edge(7, 0, 0, 32'h40000, 0, 0, 32'h50000);
    set_plane(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h7fff_ffff);
    send_edge(8, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff);
    send_edge(9, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_planes();
    for (int p = 0; p < 12; p++) begin
      set_plane(16'($urandom), 16'($urandom), 16'($urandom), rand_coord(),
                $urandom_range(1) ? $urandom_range(300000) : {1'b0, 31'($urandom)});
      random_edges(147);
    end
    idle_on = 0;
    set_plane(16'h7fff, 16'h0, 16'h0, 32'h0, 32'h10000);
    random_edges(170);
  endtask

  // Result checking and receiver back-pressure.
  always @(posedge clk) begin
    clip_res_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_edge_id_out, out_reversed, out_section_emitted, out_entry_param,
              out_exit_param, out_positive_side};
      if (clip_expected.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = clip_expected.pop_front();
        n_checked++;
        if (got.emit) n_emitted++;
        if (got !== exp_r) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 0;
    end else if (idle_on && $urandom_range(5) == 0) begin
      stall_cnt = int'($urandom_range(17, 1)) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("segment_plane_slab_clip_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_directed_default();
    test_directed_slab();
    test_random_planes();
    in_valid <= 0;
    wait (clip_expected.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d edges under 16 plane settings; %0d results checked, %0d emitted.",
             n_sent, n_checked, n_emitted);
    if (n_mismatch == 0 && clip_expected.size() == 0)
      $display("segment_plane_slab_clip_top verification clean");
    else
      $display("segment_plane_slab_clip_top verification failed");
    $finish;
  end
endmodule
